// ===== hw/rtl/bsre_pkg.sv =====
// shared types and constants of the bitmap scan and range engine
// no dependencies
`default_nettype none

package bsre_pkg;

    localparam int MAX_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int CFG_W   = 11;
    localparam int LEN_W   = 11;
    localparam int START_W = 11;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 12;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 11'd1024;

    typedef enum logic [1:0] {
        REQ_SCAN  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic setup;
        logic walk;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsre_ctrl.sv =====
// controller state machine of the bitmap scan and range engine
// depends on bsre_pkg
`default_nettype none

module bsre_ctrl
    import bsre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.hit || status.walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsre_dp.sv =====
// datapath of the bitmap scan and range engine: bitmap memory, word walk, result registers
// depends on bsre_pkg
`default_nettype none

module bsre_dp
    import bsre_pkg::*;
#(
    parameter int MAX_BITS  = MAX_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status,
    input  wire logic [CFG_W-1:0]          bits_in_use,
    input  wire logic [1:0]                req_type,
    input  wire logic signed [START_W-1:0] start_index,
    input  wire logic [LEN_W-1:0]          run_length,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic                           found,
    output logic [IDX_W-1:0]               found_index
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS + 1);
    localparam int JW        = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    req_t                       req_reg;
    logic signed [START_W-1:0]  start_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [POS_W-1:0]           lo_reg;
    logic [POS_W-1:0]           hi_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic [POS_W-1:0]           rd_base_reg;
    logic                       proc_valid_reg;
    logic [AW-1:0]              proc_addr_reg;
    logic [POS_W-1:0]           proc_base_reg;
    logic [WORD_BITS-1:0]       rdata_reg;
    logic                       res_found_reg;
    logic [IDX_W-1:0]           res_index_reg;
    logic                       out_valid_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           found_index_reg;

    logic [POS_W-1:0]           size;
    logic [POS_W-1:0]           lo_next;
    logic [POS_W-1:0]           hi_next;
    logic                       res_found_next;
    logic                       issue;
    logic signed [POS_W:0]      lo_diff;
    logic signed [POS_W:0]      hi_diff;
    logic [OFF_W-1:0]           lo_off;
    logic [OFF_W-1:0]           hi_off;
    logic [WORD_BITS-1:0]       mask;
    logic [WORD_BITS-1:0]       hit_word;
    logic [JW-1:0]              hit_pos;
    logic                       hit;
    logic [WORD_BITS-1:0]       wr_word;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [WORD_BITS-1:0]       mem_wd;
    logic [POS_W-1:0]           hit_bit;

    // effective size, clipped at the bitmap capacity
    always_comb
    begin
        if (32'(bits_in_use) > MAX_BITS)
        begin
            size = POS_W'(MAX_BITS);
        end
        else
        begin
            size = {1'b0, bits_in_use};
        end
    end

    // bit window [lo, hi) that the request walks over
    always_comb
    begin
        logic [POS_W-1:0] start_u;
        logic [POS_W-1:0] end_u;
        start_u        = {1'b0, start_reg};
        end_u          = start_u + {1'b0, len_reg};
        lo_next        = '0;
        hi_next        = '0;
        res_found_next = 1'b0;
        case (req_reg)
            REQ_SCAN:
            begin
                lo_next = start_reg[START_W-1] ? '0 : start_u + 1'b1;
                hi_next = size;
            end
            REQ_SET, REQ_CLEAR:
            begin
                res_found_next = 1'b1;
                if (!start_reg[START_W-1] && start_u < size)
                begin
                    lo_next = start_u;
                    hi_next = (end_u > size) ? size : end_u;
                end
            end
            default:
            begin
                res_found_next = 1'b0;
            end
        endcase
        if (lo_next >= hi_next)
        begin
            hi_next = '0;
        end
    end

    assign issue = cmd.walk && (rd_base_reg < hi_reg);

    // mask of the window bits within the word under work
    always_comb
    begin
        lo_diff = $signed({1'b0, lo_reg}) - $signed({1'b0, proc_base_reg});
        hi_diff = $signed({1'b0, hi_reg}) - $signed({1'b0, proc_base_reg});
        if (lo_diff < 0)
        begin
            lo_off = '0;
        end
        else if (lo_diff >= $signed((POS_W + 1)'(WORD_BITS)))
        begin
            lo_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            lo_off = lo_diff[OFF_W-1:0];
        end
        if (hi_diff < 0)
        begin
            hi_off = '0;
        end
        else if (hi_diff >= $signed((POS_W + 1)'(WORD_BITS)))
        begin
            hi_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            hi_off = hi_diff[OFF_W-1:0];
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            mask[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) < hi_off);
        end
    end

    // lowest set bit in the window
    always_comb
    begin
        hit_word = rdata_reg & mask;
        hit_pos  = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_word[j])
            begin
                hit_pos = JW'(j);
            end
        end
        hit     = cmd.walk && proc_valid_reg && (req_reg == REQ_SCAN) && (|hit_word);
        hit_bit = proc_base_reg + POS_W'(hit_pos);
    end

    always_comb
    begin
        case (req_reg)
            REQ_SET:
            begin
                wr_word = rdata_reg | mask;
            end
            REQ_CLEAR:
            begin
                wr_word = rdata_reg & ~mask;
            end
            default:
            begin
                wr_word = rdata_reg;
                if (hit)
                begin
                    wr_word[hit_pos] = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        if (cmd.clr_en)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = cmd.walk && proc_valid_reg;
            mem_wa = proc_addr_reg;
            mem_wd = wr_word;
        end
    end

    // bitmap storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.setup)
            begin
                proc_valid_reg <= 1'b0;
            end
            else
            begin
                proc_valid_reg <= issue && !hit;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg   <= req_t'(req_type);
            start_reg <= start_index;
            len_reg   <= run_length;
        end
        if (cmd.setup)
        begin
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            rd_addr_reg   <= '0;
            rd_base_reg   <= '0;
            res_found_reg <= res_found_next;
            res_index_reg <= '0;
        end
        else if (issue)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            rd_base_reg <= rd_base_reg + POS_W'(WORD_BITS);
        end
        if (issue)
        begin
            proc_addr_reg <= rd_addr_reg;
            proc_base_reg <= rd_base_reg;
        end
        if (hit)
        begin
            res_found_reg <= 1'b1;
            res_index_reg <= hit_bit[IDX_W-1:0];
        end
        if (cmd.load_out)
        begin
            found_reg       <= res_found_reg;
            found_index_reg <= res_index_reg;
        end
    end

    assign status.clr_last  = (clr_addr_reg == AW'(NUM_WORDS - 1));
    assign status.hit       = hit;
    assign status.walk_done = !(rd_base_reg < hi_reg) && !proc_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_scan_and_range_engine_core.sv =====
// top level of the bitmap scan and range engine: size register, controller and datapath
// depends on bsre_pkg, bsre_ctrl and bsre_dp
`default_nettype none

// Bitmap of MAX_BITS bits held as WORD_BITS-bit words in a single-port-write memory.
// After reset the memory is swept to zero, one word per cycle, while in_stall stays high.
// A request is then taken in the idle state, set up in the setup state, and walks the words
// from word 0 up to the word that holds the last bit of its window, one word per cycle
// through a read-modify-write pipeline (the read word is registered, then masked and written
// back) until the last word has drained; the done state hands over the result once the
// output register is free. A scan stops at the word where it finds a set bit; a request
// with an empty window walks no words. One request is in work at a time; the next one is
// taken while the previous result still waits on out_stall. The user must write bits_in_use
// through the APB port (address 0; the address is ignored) only while the engine is idle;
// the block itself does not enforce this.

module bitmap_scan_and_range_engine_core
    import bsre_pkg::*;
#(
    parameter int MAX_BITS  = MAX_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]             prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                req_type,
    input  wire logic signed [START_W-1:0] start_index,
    input  wire logic [LEN_W-1:0]          run_length,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic [IDX_W-1:0]               found_index
);

    logic [CFG_W-1:0] bits_in_use_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // single register, so the word address carries no decode
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:0] == paddr);
    assign pready    = 1'b1;
    assign prdata    = {{(PDATA_W - CFG_W){1'b0}}, bits_in_use_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= BITS_IN_USE_RST;
        end
        else if (cfg_write)
        begin
            bits_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    bsre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bsre_dp
    #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .bits_in_use (bits_in_use_reg),
        .req_type    (req_type),
        .start_index (start_index),
        .run_length  (run_length),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .found_index (found_index)
    );

endmodule

`default_nettype wire

// ===== test/bitmap_result_checker.sv =====
// watches the request, result and apb size-register traffic of the bitmap engine,
// predicts every result from its own bitmap copy and counts mismatches
// depends on bsre_pkg
module bitmap_result_checker
    import bsre_pkg::*;
#(
    parameter logic [PADDR_W-1:0] SIZE_REG_ADDR = '0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    input  logic                      pready,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic signed [START_W-1:0] start_index,
    input  logic [LEN_W-1:0]          run_length,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      found,
    input  logic [IDX_W-1:0]          found_index,
    output int                        mismatch_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] position;
    } scan_result_t;

    logic [MAX_BITS_DEF-1:0] bitmap;
    logic [CFG_W-1:0]        size_reg;
    scan_result_t            expected_results[$];

    function automatic scan_result_t apply_request(
        input logic [1:0]                kind,
        input logic signed [START_W-1:0] start,
        input logic [LEN_W-1:0]          len
    );
        scan_result_t res;
        int           size;
        int           b;
        int           stop;
        res = '0;
        size = (size_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(size_reg);
        case (kind)
            REQ_SCAN:
            begin
                b = (start < 0) ? 0 : int'(start) + 1;
                while (b < size && !res.hit)
                begin
                    if (bitmap[b])
                    begin
                        bitmap[b] = 1'b0;
                        res.hit = 1'b1;
                        res.position = b[IDX_W-1:0];
                    end
                    b++;
                end
            end
            REQ_SET, REQ_CLEAR:
            begin
                res.hit = 1'b1;
                if (start >= 0 && int'(start) < size)
                begin
                    stop = int'(start) + int'(len);
                    if (stop > size)
                        stop = size;
                    for (b = int'(start); b < stop; b++)
                        bitmap[b] = (kind == REQ_SET);
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int           errs;
        scan_result_t want;
        if (!rst_n)
        begin
            bitmap = '0;
            size_reg = BITS_IN_USE_RST;
            expected_results.delete();
            mismatch_count <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready && paddr == SIZE_REG_ADDR)
                size_reg = pwdata[CFG_W-1:0];
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: found=%0d found_index=%0d",
                           found, found_index);
                    errs++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0d, got %0d", want.hit, found);
                        errs++;
                    end
                    if (found_index !== want.position)
                    begin
                        $error("found_index: expected %0d, got %0d", want.position, found_index);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(req_type, start_index, run_length));
            mismatch_count <= mismatch_count + errs;
            pending <= expected_results.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
// stimulus and verdict for the bitmap scan and range engine: directed and random requests
// over several bitmap sizes, with random sender bursts and receiver stalls
// depends on bsre_pkg, bitmap_scan_and_range_engine_core and bitmap_result_checker
module testbench
    import bsre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] SIZE_REG_ADDR = '0;
    localparam logic [1:0]         REQ_UNKNOWN   = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                req_type;
    logic signed [START_W-1:0] start_index;
    logic [LEN_W-1:0]          run_length;
    logic                      out_valid;
    logic                      out_stall;
    logic                      found;
    logic [IDX_W-1:0]          found_index;
    int                        mismatch_count;
    int                        pending;
    int                        stall_mode;
    int                        stall_left;

    bitmap_scan_and_range_engine_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .start_index (start_index),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .found_index (found_index)
    );

    bitmap_result_checker #(
        .SIZE_REG_ADDR (SIZE_REG_ADDR)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .start_index    (start_index),
        .run_length     (run_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .found_index    (found_index),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_mode <= 0;
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 200);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    task automatic send_request(
        input logic [1:0]                kind,
        input logic signed [START_W-1:0] start,
        input logic [LEN_W-1:0]          len
    );
        in_valid <= 1'b1;
        req_type <= kind;
        start_index <= start;
        run_length <= len;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic resize_bitmap(input logic [CFG_W-1:0] bits);
        wait_for_results();
        repeat (25) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= SIZE_REG_ADDR;
        pwdata <= ($urandom << CFG_W) | bits;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                        size_plan[9];
        int                        eff;
        int                        lim;
        int                        pick;
        int                        gap;
        int                        burst_left;
        logic [1:0]                kind;
        logic signed [START_W-1:0] start;
        logic [LEN_W-1:0]          len;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = REQ_SCAN;
        start_index = '0;
        run_length = '0;
        size_plan = '{1024, 0, 1, 2047, 64, 65, 1025, 700, 0};
        size_plan[8] = $urandom_range(1, 1024);
        burst_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);

        resize_bitmap(11'd1024);
        send_request(REQ_SCAN, -1, 0);
        send_request(REQ_SET, 0, 1);
        send_request(REQ_SET, 1023, 2047);
        send_request(REQ_SET, 100, 1024);
        send_request(REQ_SCAN, -1, 2047);
        send_request(REQ_SCAN, -1024, 0);
        send_request(REQ_SCAN, 1023, 0);
        send_request(REQ_SCAN, 1022, 0);
        send_request(REQ_CLEAR, 200, 0);
        send_request(REQ_SET, 300, 0);
        send_request(REQ_CLEAR, -5, 10);
        send_request(REQ_SET, -1024, 2047);
        send_request(REQ_CLEAR, 150, 50);
        send_request(REQ_SCAN, 149, 0);
        send_request(REQ_SET, 64, 64);
        send_request(REQ_SCAN, 63, 0);
        send_request(REQ_SCAN, 126, 0);
        send_request(REQ_UNKNOWN, 5, 5);
        send_request(REQ_UNKNOWN, -1, 2047);
        send_request(REQ_CLEAR, 0, 2047);
        send_request(REQ_SCAN, -1, 0);
        send_request(REQ_SET, 1023, 1);

        foreach (size_plan[p])
        begin
            resize_bitmap(size_plan[p][CFG_W-1:0]);
            eff = (size_plan[p] > MAX_BITS_DEF) ? MAX_BITS_DEF : size_plan[p];
            lim = (eff == 0) ? 1 : eff;
            for (int n = 0; n < 200; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
                if (n == 120)
                    wait_for_results();

                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = REQ_SCAN;
                else if (pick < 68)
                    kind = REQ_SET;
                else if (pick < 94)
                    kind = REQ_CLEAR;
                else
                    kind = REQ_UNKNOWN;

                pick = $urandom_range(0, 99);
                if (pick < 8)
                    start = START_W'($urandom_range(0, 2047));
                else if (pick < 30 && kind == REQ_SCAN)
                    start = START_W'(-1);
                else
                    start = START_W'($urandom_range(0, lim - 1));

                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = LEN_W'($urandom_range(0, 2047));
                else if (pick < 25)
                    len = LEN_W'($urandom_range(0, lim));
                else
                    len = LEN_W'($urandom_range(0, 40));

                send_request(kind, start, len);
            end
        end

        wait_for_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== bitmap_scan_and_range_engine_core.f =====
hw/rtl/bsre_pkg.sv
hw/rtl/bsre_ctrl.sv
hw/rtl/bsre_dp.sv
hw/rtl/bitmap_scan_and_range_engine_core.sv
test/bitmap_result_checker.sv
test/testbench.sv
